FILE: src/bounded_array_list_engine_core_defines.svh
// assertion macros for the bounded array list engine checker
// no dependencies; included by the checker file only
`ifndef BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BALE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bale check failed");

// next-cycle implication, disabled during reset
`define BALE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bale check failed");

`endif

FILE: src/bale_pkg.sv
// shared constants and types for the bounded array list engine
// no dependencies; imported by the ram-using top level and its checker
`default_nettype none

package bale_pkg;

  // list storage sizing
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 3;
  localparam int ENTRY_W     = 2 * DATA_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // operation codes carried by kind
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND  = 3'd0,
    KIND_SEARCH  = 3'd1,
    KIND_REVERSE = 3'd2,
    KIND_ASC     = 3'd3,
    KIND_DESC    = 3'd4
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: src/bale_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bale_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/bounded_array_list_engine_core.sv
// bounded key/value list engine: append, search, reverse, order checks
// depends on bale_pkg and bale_ram
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | in        | in_valid / in_stall  | kind, item_key, item_value
//  out     | out       | out_valid / out_stall| ok, found_key, found_value, count,
//          |           |                      | full_res, empty_res
//  cfg     | in        | cfg_valid / cfg_ready| cfg_capacity
//
// one item at a time; entries live in one ram with a single read port.
// append writes the entry at once; search and order checks walk the entries in order;
// reverse swaps pairs from both ends (read low, read high, write, write per swap).
// a finished result sits in the output register; in_stall drops as soon as the
// result is loaded there, and out_stall only holds the sequencer in its final state.
// synchronous reset clears the count and presets capacity; ram contents are not cleared.
`default_nettype none

module bounded_array_list_engine_core
  import bale_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input item channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [KIND_W-1:0]       kind,
  input  wire logic signed [DATA_W-1:0] item_key,
  input  wire logic signed [DATA_W-1:0] item_value,
  // result item channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         ok,
  output logic signed [DATA_W-1:0]     found_key,
  output logic signed [DATA_W-1:0]     found_value,
  output logic [CNT_W-1:0]             count,
  output logic                         full_res,
  output logic                         empty_res,
  // capacity register write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CAP_W-1:0]        cfg_capacity
);

  state_t state, state_next;

  logic [KIND_W-1:0]        kind_r, kind_r_next;
  logic [DATA_W-1:0]        key_r, key_r_next;
  logic [CNT_W-1:0]         entry_count, entry_count_next;
  logic [CAP_W-1:0]         capacity;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [IDX_W-1:0]         hi, hi_next;
  logic [ENTRY_W-1:0]       hold, hold_next;
  logic signed [DATA_W-1:0] prev_val, prev_val_next;
  logic                     res_ok, res_ok_next;
  logic [DATA_W-1:0]        res_fk, res_fk_next;
  logic [DATA_W-1:0]        res_fv, res_fv_next;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // derived values
  logic [CMP_W-1:0]         cap_ext, eff_cap, cnt_ext;
  logic                     room;
  logic                     accept;
  logic                     out_free;
  logic [CNT_W-1:0]         idx_inc;
  logic [CNT_W-1:0]         hi_dec;
  logic                     last;
  logic [DATA_W-1:0]        cur_key;
  logic signed [DATA_W-1:0] cur_val;
  logic                     violated;

  bale_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective capacity saturates at the store depth
  assign cap_ext  = CMP_W'(capacity);
  assign eff_cap  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
  assign cnt_ext  = CMP_W'(entry_count);
  assign room     = cnt_ext < eff_cap;

  // handshakes
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // walk helpers
  assign idx_inc = CNT_W'(idx) + CNT_W'(1);
  assign hi_dec  = CNT_W'(hi) - CNT_W'(1);
  assign last    = idx_inc >= entry_count;
  assign cur_key = ram_rdata[ENTRY_W-1:DATA_W];
  assign cur_val = $signed(ram_rdata[DATA_W-1:0]);
  assign violated = (kind_r == KIND_ASC) ? (cur_val <= prev_val) : (cur_val >= prev_val);

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_capacity;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    kind_r   <= kind_r_next;
    key_r    <= key_r_next;
    idx      <= idx_next;
    hi       <= hi_next;
    hold     <= hold_next;
    prev_val <= prev_val_next;
    res_ok   <= res_ok_next;
    res_fk   <= res_fk_next;
    res_fv   <= res_fv_next;
    if (state == S_FINISH && out_free) begin
      ok          <= res_ok;
      found_key   <= $signed(res_fk);
      found_value <= $signed(res_fv);
      count       <= entry_count;
      full_res    <= cnt_ext >= eff_cap;
      empty_res   <= (entry_count == '0);
    end
  end

  // sequencer: next state, ram access and working values
  always_comb begin
    state_next       = state;
    kind_r_next      = kind_r;
    key_r_next       = key_r;
    entry_count_next = entry_count;
    idx_next         = idx;
    hi_next          = hi;
    hold_next        = hold;
    prev_val_next    = prev_val;
    res_ok_next      = res_ok;
    res_fk_next      = res_fk;
    res_fv_next      = res_fv;
    ram_we           = 1'b0;
    ram_waddr        = idx;
    ram_wdata        = hold;
    ram_raddr        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          kind_r_next = kind;
          key_r_next  = item_key;
          idx_next    = '0;
          res_ok_next = 1'b0;
          res_fk_next = '0;
          res_fv_next = '0;
          state_next  = S_FINISH;
          unique case (kind)
            KIND_APPEND: begin
              if (room) begin
                ram_we           = 1'b1;
                ram_waddr        = IDX_W'(entry_count);
                ram_wdata        = {item_key, item_value};
                entry_count_next = entry_count + CNT_W'(1);
                res_ok_next      = 1'b1;
              end
            end
            KIND_SEARCH: begin
              if (entry_count != '0) begin
                state_next = S_SCAN;
              end
            end
            KIND_REVERSE: begin
              res_ok_next = 1'b1;
              hi_next     = IDX_W'(entry_count - CNT_W'(1));
              if (entry_count >= CNT_W'(2)) begin
                state_next = S_REV_A;
              end
            end
            KIND_ASC, KIND_DESC: begin
              res_ok_next = 1'b1;
              if (entry_count >= CNT_W'(2)) begin
                state_next = S_SCAN;
              end
            end
            default: begin
              // unused kinds leave the list untouched and report not ok
            end
          endcase
        end
      end

      S_SCAN: begin
        // data for idx is on the ram output; prefetch the next entry
        ram_raddr = IDX_W'(idx_inc);
        if (kind_r == KIND_SEARCH) begin
          if (cur_key == key_r) begin
            res_ok_next = 1'b1;
            res_fk_next = cur_key;
            res_fv_next = cur_val;
            state_next  = S_FINISH;
          end else if (last) begin
            state_next = S_FINISH;
          end else begin
            idx_next = IDX_W'(idx_inc);
          end
        end else begin
          prev_val_next = cur_val;
          if (idx != '0 && violated) begin
            res_ok_next = 1'b0;
            state_next  = S_FINISH;
          end else if (last) begin
            state_next = S_FINISH;
          end else begin
            idx_next = IDX_W'(idx_inc);
          end
        end
      end

      S_REV_A: begin
        // low entry arrives; fetch the high one
        hold_next  = ram_rdata;
        ram_raddr  = hi;
        state_next = S_REV_B;
      end

      S_REV_B: begin
        // high entry goes to the low slot
        ram_we     = 1'b1;
        ram_waddr  = idx;
        ram_wdata  = ram_rdata;
        state_next = S_REV_C;
      end

      S_REV_C: begin
        // held low entry goes to the high slot; fetch the next low entry
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = hold;
        ram_raddr = IDX_W'(idx_inc);
        idx_next  = IDX_W'(idx_inc);
        hi_next   = IDX_W'(hi_dec);
        if (idx_inc < hi_dec) begin
          state_next = S_REV_A;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/bale_chk.sv
// port-level checker for the bounded array list engine, bound to the top level
// depends on bale_pkg and bounded_array_list_engine_core_defines.svh
`include "bounded_array_list_engine_core_defines.svh"
`default_nettype none

module bale_chk
  import bale_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     ok,
  input wire logic signed [DATA_W-1:0] found_key,
  input wire logic signed [DATA_W-1:0] found_value,
  input wire logic [CNT_W-1:0]         count,
  input wire logic                     empty_res
);

  // one item at a time: an accepted item closes the input side
  `BALE_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

  // a result that is not ok carries no entry
  `BALE_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok,
                   found_key == '0 && found_value == '0)

  // count never runs past the store depth, and empty agrees with it
  `BALE_ASSERT_NOW(a_count_range, clk, rst, out_valid,
                   count <= CNT_W'(MAX_ENTRIES) && empty_res == (count == '0))

  // a stalled result is held
  `BALE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(ok) && $stable(count) && $stable(found_key))

endmodule

bind bounded_array_list_engine_core bale_chk u_bale_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .found_key   (found_key),
  .found_value (found_value),
  .count       (count),
  .empty_res   (empty_res)
);

`default_nettype wire
